// ----- design/sut_pkg.sv -----
package sut_pkg;

  // data word width of one table entry
  localparam int WORD_W = 32;

  // width of the count and capacity fields on the ports
  localparam int CNT_W = 7;

  // operation codes carried by the mode field
  localparam logic [1:0] MODE_INSERT       = 2'd0;
  localparam logic [1:0] MODE_REMOVE_FIRST = 2'd1;
  localparam logic [1:0] MODE_REMOVE_ALL   = 2'd2;

  // status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // result word handed from the sequencer to the output register
  typedef struct packed {
    logic             status;
    logic [CNT_W-1:0] removed_count;
    logic [CNT_W-1:0] fill_count;
  } result_t;

endpackage

// ----- design/sut_mem.sv -----
module sut_mem #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [sut_pkg::WORD_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [sut_pkg::WORD_W-1:0] rdata
);

  logic [sut_pkg::WORD_W-1:0] mem [DEPTH];

  // one write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // one registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/sut_ctrl.sv -----
module sut_ctrl #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [1:0]                        mode,
  input  logic signed [sut_pkg::WORD_W-1:0] value,
  input  logic [sut_pkg::CNT_W-1:0]         capacity,
  output logic                              idle,
  output logic                              res_valid,
  input  logic                              res_ready,
  output sut_pkg::result_t                  res,
  output logic                              mem_we,
  output logic [AW-1:0]                     mem_waddr,
  output logic [sut_pkg::WORD_W-1:0]        mem_wdata,
  output logic                              mem_re,
  output logic [AW-1:0]                     mem_raddr,
  input  logic [sut_pkg::WORD_W-1:0]        mem_rdata
);

  localparam int XW = (CW > sut_pkg::CNT_W) ? CW : sut_pkg::CNT_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;
  localparam logic [1:0] S_REPORT = 2'd3;

  // scan phases: looking for the slot, carrying right, pulling left
  localparam logic [1:0] P_FIND    = 2'd0;
  localparam logic [1:0] P_SHIFT_R = 2'd1;
  localparam logic [1:0] P_SHIFT_L = 2'd2;

  logic [1:0]                        state, state_next;
  logic [1:0]                        phase, phase_next;
  logic [CW-1:0]                     count, count_next;
  logic [CW-1:0]                     issue, issue_next;
  logic                              rv, rv_next;
  logic [AW-1:0]                     ridx, ridx_next;
  logic [sut_pkg::WORD_W-1:0]        carry, carry_next;
  logic                              res_status, status_next;
  logic                              res_removed, removed_next;
  logic [1:0]                        mode_r;
  logic signed [sut_pkg::WORD_W-1:0] value_r;

  logic [XW-1:0]                     cap_x;
  logic [XW-1:0]                     cap_sel;
  logic [CW-1:0]                     cap_eff;
  logic                              full;
  logic                              is_insert;
  logic                              is_remove;
  logic                              in_known;
  logic                              last;
  logic signed [sut_pkg::WORD_W-1:0] rd_s;
  logic                              lt;
  logic                              eq;

  // effective capacity: zero acts as one, clipped at the table depth
  always_comb begin
    cap_x = XW'(capacity);
    if (cap_x == '0) begin
      cap_sel = XW'(1);
    end else if (cap_x > XW'(DEPTH)) begin
      cap_sel = XW'(DEPTH);
    end else begin
      cap_sel = cap_x;
    end
    cap_eff = CW'(cap_sel);
  end

  assign full      = (count >= cap_eff);
  assign is_insert = (mode_r == sut_pkg::MODE_INSERT);
  assign is_remove = (mode_r == sut_pkg::MODE_REMOVE_FIRST) ||
                     (mode_r == sut_pkg::MODE_REMOVE_ALL);
  assign in_known  = (mode == sut_pkg::MODE_INSERT) ||
                     (mode == sut_pkg::MODE_REMOVE_FIRST) ||
                     (mode == sut_pkg::MODE_REMOVE_ALL);

  // the shared compare unit on the entry just read
  assign rd_s = $signed(mem_rdata);
  assign lt   = (rd_s < value_r);
  assign eq   = (rd_s == value_r);
  assign last = ((CW'(ridx) + CW'(1)) == count);

  // sequencer
  always_comb begin
    state_next   = state;
    phase_next   = phase;
    count_next   = count;
    issue_next   = issue;
    rv_next      = 1'b0;
    ridx_next    = ridx;
    carry_next   = carry;
    status_next  = res_status;
    removed_next = res_removed;
    mem_re       = 1'b0;
    mem_raddr    = issue[AW-1:0];
    mem_we       = 1'b0;
    mem_waddr    = ridx;
    mem_wdata    = carry;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          issue_next   = '0;
          phase_next   = P_FIND;
          status_next  = sut_pkg::STATUS_ERR;
          removed_next = 1'b0;
          if (!in_known) begin
            state_next = S_REPORT;
          end else if (count == '0) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // walk the table one entry a cycle
        if (issue != count) begin
          mem_re     = 1'b1;
          issue_next = issue + CW'(1);
          rv_next    = 1'b1;
          ridx_next  = issue[AW-1:0];
        end
        if (rv) begin
          case (phase)
            P_FIND: begin
              if (lt) begin
                if (last) begin
                  state_next = S_FINISH;
                end
              end else if (eq) begin
                if (is_insert) begin
                  // duplicate: table stays as is
                  state_next = S_REPORT;
                end else begin
                  phase_next = P_SHIFT_L;
                  if (last) begin
                    state_next = S_FINISH;
                  end
                end
              end else begin
                if (is_insert) begin
                  mem_we     = 1'b1;
                  mem_waddr  = ridx;
                  mem_wdata  = value_r;
                  carry_next = mem_rdata;
                  phase_next = P_SHIFT_R;
                  if (last) begin
                    state_next = S_FINISH;
                  end
                end else begin
                  // passed the place where the value would be: absent
                  state_next = S_REPORT;
                end
              end
            end
            P_SHIFT_R: begin
              mem_we     = 1'b1;
              mem_waddr  = ridx;
              mem_wdata  = carry;
              carry_next = mem_rdata;
              if (last) begin
                state_next = S_FINISH;
              end
            end
            P_SHIFT_L: begin
              mem_we    = 1'b1;
              mem_waddr = ridx - AW'(1);
              mem_wdata = mem_rdata;
              if (last) begin
                state_next = S_FINISH;
              end
            end
            default: begin
              state_next = S_REPORT;
            end
          endcase
        end
      end

      S_FINISH: begin
        // tail write and count update
        state_next = S_REPORT;
        if (is_insert) begin
          if (phase == P_SHIFT_R) begin
            status_next = sut_pkg::STATUS_OK;
            if (full) begin
              removed_next = 1'b1;
            end else begin
              mem_we     = 1'b1;
              mem_waddr  = count[AW-1:0];
              mem_wdata  = carry;
              count_next = count + CW'(1);
            end
          end else if (!full) begin
            status_next = sut_pkg::STATUS_OK;
            mem_we      = 1'b1;
            mem_waddr   = count[AW-1:0];
            mem_wdata   = value_r;
            count_next  = count + CW'(1);
          end
        end else if (is_remove && (phase == P_SHIFT_L)) begin
          status_next  = sut_pkg::STATUS_OK;
          removed_next = 1'b1;
          count_next   = count - CW'(1);
        end
      end

      S_REPORT: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      rv    <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      rv    <= rv_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    phase       <= phase_next;
    issue       <= issue_next;
    ridx        <= ridx_next;
    carry       <= carry_next;
    res_status  <= status_next;
    res_removed <= removed_next;
    if (start) begin
      mode_r  <= mode;
      value_r <= value;
    end
  end

  assign idle                = (state == S_IDLE);
  assign res_valid           = (state == S_REPORT);
  assign res.status          = res_status;
  assign res.removed_count   = sut_pkg::CNT_W'(res_removed);
  assign res.fill_count      = sut_pkg::CNT_W'(count);

endmodule

// ----- design/sorted_unique_table_unit.sv -----
// flow: an accepted word is compared against the table entries in the scan state, then
// passes the finish and report states to the output register; an empty table skips the
// scan, and a duplicate insert or an absent value can end the walk early; one word at a
// time, a new word is taken only back in idle; the single read port of the table memory is walked one entry per cycle
// reset: control, fill count and output valid flag cleared, capacity set to 64; table
// contents stay undefined, no clearing pass
module sorted_unique_table_unit #(
  parameter int DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        mode,
  input  logic signed [sut_pkg::WORD_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              status,
  output logic [sut_pkg::CNT_W-1:0]         removed_count,
  output logic [sut_pkg::CNT_W-1:0]         fill_count,
  input  logic                              cfg_we,
  input  logic [sut_pkg::CNT_W-1:0]         cfg_wdata
);

  localparam int AW = $clog2(DEPTH);

  logic [sut_pkg::CNT_W-1:0]  capacity;
  logic                       start;
  logic                       idle;
  logic                       res_valid;
  logic                       res_ready;
  sut_pkg::result_t           res;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [sut_pkg::WORD_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic [sut_pkg::WORD_W-1:0] mem_rdata;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= sut_pkg::CNT_W'(64);
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  assign in_ready  = idle;
  assign start     = in_valid && idle;
  assign res_ready = !out_valid || out_ready;

  sut_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .mode      (mode),
    .value     (value),
    .capacity  (capacity),
    .idle      (idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  sut_mem #(.DEPTH(DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      status        <= res.status;
      removed_count <= res.removed_count;
      fill_count    <= res.fill_count;
    end
  end

endmodule

// ----- design/sut_checker.sv -----
module sut_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      status,
  input logic [sut_pkg::CNT_W-1:0] removed_count,
  input logic [sut_pkg::CNT_W-1:0] fill_count
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
    $stable(removed_count) && $stable(fill_count))
    else $error("result word changed while stalled");

  // entries are unique, so one operation removes at most one
  a_removed_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> removed_count <= sut_pkg::CNT_W'(1))
    else $error("more than one entry removed");

  // an error leaves the table alone
  a_err_no_remove: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == sut_pkg::STATUS_ERR) |-> removed_count == '0)
    else $error("error word reports removed entries");

  // the unit is busy right after it takes a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready again right after accept");

endmodule

bind sorted_unique_table_unit sut_checker u_sut_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .status        (status),
  .removed_count (removed_count),
  .fill_count    (fill_count)
);
